// File: sv/sfe_pkg.sv
// Package with the types, constants and escape function of the SLIP frame encoder.
package sfe_pkg;

	localparam logic [7:0] DELIM   = 8'hC0;
	localparam logic [7:0] ESC     = 8'hDB;
	localparam logic [7:0] ESC_END = 8'hDC;
	localparam logic [7:0] ESC_ESC = 8'hDD;

	localparam int MaxOut = 6;
	localparam int CntW   = $clog2(MaxOut + 1);
	localparam int IdxW   = $clog2(MaxOut);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       empty_frame;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_t;

	typedef struct packed {
		logic       two;
		logic [7:0] first;
		logic [7:0] second;
	} esc_t;

	function automatic esc_t escape(input logic [7:0] b);
		esc_t e;
		e.two    = 1'b0;
		e.first  = b;
		e.second = 8'h00;
		if (b == DELIM) begin
			e.two    = 1'b1;
			e.first  = ESC;
			e.second = ESC_END;
		end else if (b == ESC) begin
			e.two    = 1'b1;
			e.first  = ESC;
			e.second = ESC_ESC;
		end
		return e;
	endfunction

endpackage

// File: sv/slip_frame_encoder_xor.sv
// SLIP frame encoder with an escaped XOR checksum ahead of the closing delimiter.
//
// Usage: payload bytes enter on the in channel (in_valid/in_ready/in_data), one
// transaction per byte, with last_byte on the final byte of a frame, or a
// transaction with empty_frame set to close the open frame (or to send an empty
// frame). Encoded line bytes leave on the out channel, one per transaction;
// run_last marks the last byte caused by an input transaction and frame_end
// marks the closing delimiter.
// An accepted item waits in the input register until the buffer is free, then its
// whole expansion (one to six bytes) is computed in one pass and loaded into a
// six-entry output buffer. The buffer sends one byte per cycle while out_ready is
// high, so an item takes one to six output bytes: one for a plain mid-frame byte,
// two for an escaped one, up to six for an escaped last byte that opens a frame
// and has an escaped checksum. The next item is taken into the input register
// while the buffer still drains, and it loads as the buffer's last byte leaves.
// Reset clears the frame state, the checksum and both valid flags.
// When the receiver stalls, the buffer holds its byte and, once the input
// register is full, in_ready drops until the buffer can take the next item.
module slip_frame_encoder_xor
	import sfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic            valid_s1;
	in_t             item_s1;
	logic            inside_q;
	logic [7:0]      xor_q;
	out_t            buf_q [MaxOut];
	logic [CntW-1:0] cnt_q;

	out_t            seq [MaxOut];
	logic [CntW-1:0] n;
	logic [7:0]      x_base;
	logic [7:0]      x_new;
	esc_t            esc_d;
	esc_t            esc_c;
	logic            close;
	logic            buf_free;
	logic            load;
	logic            out_fire;

	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[0];
	assign out_fire  = out_valid && out_ready;
	assign buf_free  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready);
	assign load      = valid_s1 && buf_free;
	assign in_ready  = !valid_s1 || load;

	always_comb begin
		for (int i = 0; i < MaxOut; i++) begin
			seq[i] = '0;
		end
		n      = '0;
		x_base = inside_q ? xor_q : 8'h00;
		esc_d  = escape(item_s1.data_byte);
		x_new  = x_base;
		close  = item_s1.empty_frame || item_s1.last_byte;
		if (!inside_q) begin
			seq[n[IdxW-1:0]].out_byte = DELIM;
			n = n + CntW'(1);
		end
		if (!item_s1.empty_frame) begin
			seq[n[IdxW-1:0]].out_byte = esc_d.first;
			n = n + CntW'(1);
			if (esc_d.two) begin
				seq[n[IdxW-1:0]].out_byte = esc_d.second;
				n = n + CntW'(1);
			end
			x_new = x_base ^ esc_d.first ^ (esc_d.two ? esc_d.second : 8'h00);
		end
		esc_c = escape(x_new);
		if (close) begin
			seq[n[IdxW-1:0]].out_byte = esc_c.first;
			n = n + CntW'(1);
			if (esc_c.two) begin
				seq[n[IdxW-1:0]].out_byte = esc_c.second;
				n = n + CntW'(1);
			end
			seq[n[IdxW-1:0]].out_byte  = DELIM;
			seq[n[IdxW-1:0]].frame_end = 1'b1;
			n = n + CntW'(1);
		end
		seq[IdxW'(n - CntW'(1))].run_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			inside_q <= 1'b0;
			xor_q    <= 8'h00;
			cnt_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load) begin
				cnt_q    <= n;
				inside_q <= !close;
				xor_q    <= close ? 8'h00 : x_new;
			end else if (out_fire) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (load) begin
			for (int i = 0; i < MaxOut; i++) begin
				buf_q[i] <= seq[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < MaxOut - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

endmodule

// File: sv/sfe_checker.sv
// Port-level checker for the SLIP frame encoder and its bind to the top level.
module sfe_checker
	import sfe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Output transaction changed while stalled.");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.run_last)
		else $error("Closing delimiter is not the last byte of its item.");

	a_end_is_delim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.out_byte == DELIM)
		else $error("Closing byte is not a delimiter.");

	a_open_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_byte == DELIM && !out_data.frame_end
		|-> !out_data.run_last)
		else $error("Opening delimiter ends an item.");

endmodule

bind slip_frame_encoder_xor sfe_checker u_sfe_checker (.*);
